>>> rtl/shpt_pkg.sv
// Shared types, constants and helpers for the sampled hash position table.
// No dependencies; used by the top, shpt_ctrl and shpt_dp.
package shpt_pkg;

	localparam int TABLE_DEPTH_DEF = 8192;
	localparam int KEY_BITS_DEF    = 32;
	localparam int POS_BITS_DEF    = 48;
	localparam int SAMPLE_SIZE_DEF = 32;

	localparam int PRIME_W = 14;
	localparam int QUAL_W  = 7;
	localparam int CNT_W   = 32;

	localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(8191);

	localparam logic [CNT_W-1:0] THRESH_STEP      = CNT_W'(4);
	localparam logic [CNT_W-1:0] COLL_STEP_GOOD   = CNT_W'(4);
	localparam logic [CNT_W-1:0] COLL_STEP_POOR   = CNT_W'(1);
	localparam logic [CNT_W-1:0] RELIABILITY_STEP = CNT_W'(4);
	localparam int               GOOD_MARGIN      = 4;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic clr_we;
		logic take;
		logic div_step;
		logic mem_go;
		logic res_load;
	} ctrl_t;

	typedef struct packed {
		logic clr_done;
		logic out_free;
	} stat_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

>>> rtl/sampled_hash_position_table_unit.sv
// Top level of the sampled hash position table: controller plus datapath.
// Depends on shpt_pkg, shpt_ctrl and shpt_dp.
//
//  channel   handshake                  payload
//  ---------------------------------------------------------------------
//  input     s_tvalid / s_tready        s_tdata, s_tuser (command)
//  result    m_tvalid / m_tready        m_tdata
//  config    cfg_valid / cfg_ready      cfg_data (table_prime)
//
// After reset the entry memory is swept to zero before the first item is taken;
// config writes are taken throughout.
// Each item passes through the bit-serial modulo divider and one memory
// access. One item is in work at a time.
// A finished result waits in the output register while the next item runs.
module sampled_hash_position_table_unit #(
	parameter int TABLE_DEPTH = shpt_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = shpt_pkg::KEY_BITS_DEF,
	parameter int POS_BITS    = shpt_pkg::POS_BITS_DEF,
	parameter int SAMPLE_SIZE = shpt_pkg::SAMPLE_SIZE_DEF,
	localparam int IN_TW  = ((KEY_BITS + POS_BITS + shpt_pkg::QUAL_W + 7) / 8) * 8,
	localparam int OUT_TW = ((2 + POS_BITS + 2 * shpt_pkg::CNT_W + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_TW-1:0]             s_tdata,   // key, position, quality
	input  logic                         s_tuser,   // command
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_TW-1:0]            m_tdata,   // found, found_position, stored,
	                                                // reliability_range, hit_total
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [shpt_pkg::PRIME_W-1:0] cfg_data
);

	shpt_pkg::ctrl_t ctrl;
	shpt_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	shpt_ctrl #(
		.KEY_BITS(KEY_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	shpt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS   (KEY_BITS),
		.POS_BITS   (POS_BITS),
		.SAMPLE_SIZE(SAMPLE_SIZE),
		.IN_TW      (IN_TW),
		.OUT_TW     (OUT_TW)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_data  (s_tdata),
		.in_cmd   (s_tuser),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (m_tdata)
	);

endmodule

>>> rtl/shpt_ctrl.sv
// Sequencer for the hash position table: clearing pass, divide steps,
// memory access and result hand-off. Depends on shpt_pkg.
module shpt_ctrl #(
	parameter int KEY_BITS = shpt_pkg::KEY_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  shpt_pkg::stat_t stat,
	output shpt_pkg::ctrl_t ctrl
);

	localparam int CW = $clog2(KEY_BITS);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MEM  = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] step_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				ctrl.clr_we = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ctrl.take = in_valid;
				if (in_valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (step_q == CW'(KEY_BITS - 1)) begin
					state_d = S_MEM;
				end
			end
			S_MEM: begin
				ctrl.mem_go = 1'b1;
				state_d     = S_RES;
			end
			S_RES: begin
				ctrl.res_load = stat.out_free;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.take) begin
				step_q <= '0;
			end else if (ctrl.div_step) begin
				step_q <= step_q + CW'(1);
			end
		end
	end

endmodule

>>> rtl/shpt_dp.sv
// Datapath of the hash position table: modulo divider, entry memory,
// load and collision counters, output register. Depends on shpt_pkg.
module shpt_dp #(
	parameter int TABLE_DEPTH = shpt_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = shpt_pkg::KEY_BITS_DEF,
	parameter int POS_BITS    = shpt_pkg::POS_BITS_DEF,
	parameter int SAMPLE_SIZE = shpt_pkg::SAMPLE_SIZE_DEF,
	parameter int IN_TW       = 88,
	parameter int OUT_TW      = 120
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  shpt_pkg::ctrl_t              ctrl,
	output shpt_pkg::stat_t              stat,
	input  logic                         cfg_valid,
	input  logic [shpt_pkg::PRIME_W-1:0] cfg_data,
	input  logic [IN_TW-1:0]             in_data,
	input  logic                         in_cmd,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [OUT_TW-1:0]            out_data
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int MW    = $clog2(TABLE_DEPTH + 1);
	localparam int DW    = KEY_BITS + POS_BITS;
	localparam int CNT_W = shpt_pkg::CNT_W;
	localparam int QW    = shpt_pkg::QUAL_W;
	localparam int OUT_BITS = 2 + POS_BITS + 2 * CNT_W;

	localparam logic [CNT_W-1:0] REL_RESET  = CNT_W'(SAMPLE_SIZE + SAMPLE_SIZE / 2);
	localparam logic [QW:0]      QUAL_LIMIT = (QW + 1)'(SAMPLE_SIZE);

	logic [shpt_pkg::PRIME_W-1:0] prime_q;
	logic [AW-1:0]                clr_q;
	logic [MW-1:0]                mod_q;
	logic [MW-1:0]                mod_c;
	logic [31:0]                  prime_ext;
	logic [MW-1:0]                load_q;
	logic [CNT_W-1:0]             thr_q;
	logic [CNT_W-1:0]             coll_q;
	logic [CNT_W-1:0]             coll_new;
	logic [CNT_W-1:0]             rel_q;
	logic [CNT_W-1:0]             hit_q;
	logic [CNT_W-1:0]             hit_new;
	logic                         cmd_q;
	logic [KEY_BITS-1:0]          key_q;
	logic [KEY_BITS-1:0]          div_q;
	logic [POS_BITS-1:0]          pos_q;
	logic [QW-1:0]                qual_q;
	logic [AW-1:0]                rem_q;
	logic [AW:0]                  rem_sh;
	logic [AW:0]                  mod_ext;
	logic                         good;
	logic                         stored_q;
	logic                         hit;
	logic                         do_write;
	logic [AW-1:0]                wr_addr;
	logic [DW-1:0]                wr_data;
	logic [DW-1:0]                rd_q;
	logic [DW-1:0]                mem_q [TABLE_DEPTH];
	logic                         out_valid_q;
	logic [OUT_BITS-1:0]          out_q;
	logic [POS_BITS-1:0]          fpos;

	assign prime_ext = 32'(prime_q);

	always_comb begin
		if (prime_ext < 32'd2) begin
			mod_c = MW'(2);
		end else if (prime_ext > 32'(TABLE_DEPTH)) begin
			mod_c = MW'(TABLE_DEPTH);
		end else begin
			mod_c = MW'(prime_ext);
		end
	end

	assign rem_sh  = {rem_q, div_q[KEY_BITS-1]};
	assign mod_ext = (AW + 1)'(mod_q);
	assign good    = ({1'b0, qual_q} + (QW + 1)'(shpt_pkg::GOOD_MARGIN)) <= QUAL_LIMIT;
	assign coll_new = shpt_pkg::sat_add(coll_q,
		good ? shpt_pkg::COLL_STEP_GOOD : shpt_pkg::COLL_STEP_POOR);
	assign hit     = (cmd_q == shpt_pkg::CMD_LOOKUP) && (rd_q[KEY_BITS-1:0] == key_q);
	assign hit_new = hit ? shpt_pkg::sat_add(hit_q, CNT_W'(1)) : hit_q;
	assign fpos    = hit ? rd_q[DW-1:KEY_BITS] : '0;

	assign do_write = ctrl.clr_we ||
		(ctrl.mem_go && (cmd_q == shpt_pkg::CMD_ADD) && (coll_new >= thr_q));
	assign wr_addr  = ctrl.clr_we ? clr_q : rem_q;
	assign wr_data  = ctrl.clr_we ? '0 : {pos_q, key_q};

	assign stat.clr_done = (clr_q == AW'(TABLE_DEPTH - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = OUT_TW'(out_q);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctrl.mem_go) begin
			rd_q <= mem_q[rem_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			cmd_q  <= in_cmd;
			key_q  <= in_data[KEY_BITS-1:0];
			div_q  <= in_data[KEY_BITS-1:0];
			pos_q  <= in_data[KEY_BITS +: POS_BITS];
			qual_q <= in_data[DW +: QW];
			mod_q  <= mod_c;
			rem_q  <= '0;
		end else if (ctrl.div_step) begin
			div_q <= div_q << 1;
			if (rem_sh >= mod_ext) begin
				rem_q <= AW'(rem_sh - mod_ext);
			end else begin
				rem_q <= AW'(rem_sh);
			end
		end
		if (ctrl.mem_go) begin
			stored_q <= (cmd_q == shpt_pkg::CMD_ADD) && (coll_new >= thr_q);
		end
		if (ctrl.res_load) begin
			out_q <= {hit_new, rel_q, stored_q && (cmd_q == shpt_pkg::CMD_ADD), fpos, hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q     <= shpt_pkg::PRIME_RESET;
			clr_q       <= '0;
			load_q      <= '0;
			thr_q       <= shpt_pkg::THRESH_STEP;
			coll_q      <= shpt_pkg::THRESH_STEP;
			rel_q       <= REL_RESET;
			hit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				prime_q <= cfg_data;
			end
			if (ctrl.clr_we && !stat.clr_done) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctrl.take && (in_cmd == shpt_pkg::CMD_ADD)) begin
				if (load_q < mod_c) begin
					load_q <= load_q + MW'(1);
				end else begin
					load_q <= '0;
					thr_q  <= shpt_pkg::sat_add(thr_q, shpt_pkg::THRESH_STEP);
					rel_q  <= shpt_pkg::sat_add(rel_q, shpt_pkg::RELIABILITY_STEP);
				end
			end
			if (ctrl.mem_go && (cmd_q == shpt_pkg::CMD_ADD)) begin
				coll_q <= (coll_new >= thr_q) ? '0 : coll_new;
			end
			if (ctrl.res_load) begin
				hit_q       <= hit_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/shpt_chk.sv
// Port-level checks for the sampled hash position table, bound to the top.
// Depends on sampled_hash_position_table_unit's ports only.
module shpt_chk #(
	parameter int POS_BITS = 48,
	parameter int OUT_TW   = 120
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[POS_BITS:1] == '0))
		else $error("position reported without a match");

	a_found_or_stored: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[POS_BITS+1]))
		else $error("result marks both a match and a store");

endmodule

bind sampled_hash_position_table_unit shpt_chk #(
	.POS_BITS(POS_BITS),
	.OUT_TW  (OUT_TW)
) u_shpt_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
